/* rtl/phaser_pkg.sv */
// -----------------------------------------------------------------------------
// Phaser package
// Shared widths, limits, register and state codes for the all-pass phaser.
// -----------------------------------------------------------------------------
package phaser_pkg;

   localparam int SMP_W      = 16;   // Q1.15 audio sample
   localparam int SIG_W      = 18;   // Q3.15 internal signal
   localparam int DIF_W      = 19;   // stage difference x - y_prev
   localparam int COEF_W     = 16;   // Q1.15 coefficient and gain
   localparam int MUL_A_W    = 17;
   localparam int MUL_B_W    = 19;
   localparam int PROD_W     = 36;
   localparam int RND_W      = 21;   // rounded product
   localparam int SAT_W      = 22;   // headroom ahead of saturation
   localparam int PHASE_W    = 32;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int FRAC_BITS  = 15;

   localparam int ONE_Q15  = 32768;
   localparam int GAIN_09  = 29491;
   localparam int RND_HALF = 16384;

   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic signed [SAT_W-1:0] SIG_HI = SAT_W'(131071);
   localparam logic signed [SAT_W-1:0] SIG_LO = SAT_W'(-131072);
   localparam logic signed [SAT_W-1:0] WET_HI = SAT_W'(39322);
   localparam logic signed [SAT_W-1:0] WET_LO = SAT_W'(-39322);
   localparam logic signed [SAT_W-1:0] OUT_HI = SAT_W'(32767);
   localparam logic signed [SAT_W-1:0] OUT_LO = SAT_W'(-32768);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP,
      CSR_SWEEP_DEPTH,
      CSR_FEEDBACK_GAIN,
      CSR_WET_MIX
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_GAIN_RND,
      ST_COEF,
      ST_COEF_RND,
      ST_STG_DIF,
      ST_STG_MUL,
      ST_STG_RND,
      ST_WET,
      ST_MIX,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_GAIN,
      MUL_FB,
      MUL_COEF,
      MUL_STAGE,
      MUL_DRY,
      MUL_WET
   } mul_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        mem_re;
      logic        mem_we;
      logic        out_load;
   } ctrl_type;

endpackage

/* rtl/phaser_allpass_cascade_fx_top.sv */
// -----------------------------------------------------------------------------
// Phaser all-pass cascade, top level
// Sine-swept cascade of first-order all-pass stages with feedback and dry/wet
// mix. Stage history lives in a synchronous memory, one entry per stage.
// -----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  req_sample_in  (s16 Q1.15)
//   rsp_     out        rsp_valid/rsp_ready  rsp_sample_out (s16 Q1.15)
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// An item's sequence is set by the shared 17x19 multiplier and the
// read-modify-write of each stage entry in the history memory.
// Reset clears control registers, phase, feedback and the per-entry valid bits; no
// clearing pass. A result held on the output does not block the next item
// until that item is ready to leave; the sequencer then waits for rsp_ready.
// -----------------------------------------------------------------------------
module phaser_allpass_cascade_fx_top
   import phaser_pkg::*;
#(
   parameter int NUM_STAGES      = 4,
   parameter int SINE_TABLE_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [SMP_W-1:0]     req_sample_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SMP_W-1:0]     rsp_sample_out,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int STAGE_AW  = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
   localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;
   localparam int QTR_BITS  = SINE_TABLE_BITS - 2;
   localparam logic [STAGE_AW-1:0] LAST_STAGE = STAGE_AW'(NUM_STAGES - 1);

   // quarter-wave Taylor series in Q30, folded to a full cycle
   function automatic logic signed [SMP_W-1:0] sine_entry(input int unsigned k);
      logic [63:0] n;
      logic [63:0] quad;
      logic [63:0] r;
      logic [63:0] m;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      n    = 64'd1 << QTR_BITS;
      quad = (64'(k) >> QTR_BITS) & 64'd3;
      r    = 64'(k) & (n - 64'd1);
      m    = quad[0] ? (n - r) : r;
      x    = (m * HALF_PI_Q30) >> QTR_BITS;
      x2   = (x * x) >> 30;
      t    = ONE_Q30 - x2 / 64'd110;
      t    = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t    = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t    = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t    = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s    = (x * t) >> 30;
      s    = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return quad[1] ? -SMP_W'(s) : SMP_W'(s);
   endfunction

   // round half up, floor((p + 2^14) / 2^15)
   function automatic logic signed [RND_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + PROD_W'(RND_HALF);
      return RND_W'(t >>> FRAC_BITS);
   endfunction

   function automatic logic signed [SAT_W-1:0] clip(input logic signed [SAT_W-1:0] v,
                                                    input logic signed [SAT_W-1:0] hi,
                                                    input logic signed [SAT_W-1:0] lo);
      logic signed [SAT_W-1:0] res;
      res = v;
      if (v > hi) begin
         res = hi;
      end else if (v < lo) begin
         res = lo;
      end
      return res;
   endfunction

   // sine table, fixed at elaboration
   logic signed [SMP_W-1:0] sine_tab [SINE_SIZE];
   for (genvar k = 0; k < SINE_SIZE; k++) begin : g_sine
      assign sine_tab[k] = sine_entry(k);
   end

   state_type                  state_ff, state_in;
   ctrl_type                   ctrl;

   logic [PHASE_W-1:0]         phase_ff;
   logic [CSR_DATA_W-1:0]      step_ff;
   logic [SMP_W-1:0]           depth_ff;
   logic signed [SMP_W-1:0]    fbg_ff;
   logic [SMP_W-1:0]           mix_ff;
   logic signed [SIG_W-1:0]    wet_fb_ff;
   logic [NUM_STAGES-1:0]      vld_ff;
   logic [STAGE_AW-1:0]        stage_ff;
   logic                       rsp_valid_ff;
   logic signed [SMP_W-1:0]    rsp_data_ff;

   logic signed [SMP_W-1:0]    x_in_ff;
   logic signed [SMP_W-1:0]    sine_ff;
   logic signed [COEF_W-1:0]   g_ff;
   logic signed [COEF_W-1:0]   a_ff;
   logic signed [SIG_W-1:0]    sig_ff;
   logic signed [DIF_W-1:0]    d_ff;
   logic signed [SIG_W-1:0]    prev_in_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   acc_ff;

   logic [2*SIG_W-1:0]         stage_mem [NUM_STAGES];
   logic [2*SIG_W-1:0]         mem_rd_ff;
   logic                       rd_vld_ff;
   logic [STAGE_AW-1:0]        rd_addr;
   logic signed [SIG_W-1:0]    rd_in;
   logic signed [SIG_W-1:0]    rd_out;

   logic [MUL_A_W-1:0]         depth_eff;
   logic [MUL_A_W-1:0]         mix_eff;
   logic [MUL_A_W-1:0]         dry_eff;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [SIG_W-1:0]    y_new;
   logic signed [PROD_W-1:0]   mix_sum;
   logic                       req_acc;
   logic                       last_stage;

   assign req_ready      = ctrl.req_ready;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign req_acc        = req_valid && ctrl.req_ready;
   assign last_stage     = (stage_ff == LAST_STAGE);

   // depth and mix saturate at one
   assign depth_eff = (depth_ff > SMP_W'(ONE_Q15)) ? MUL_A_W'(ONE_Q15) : MUL_A_W'(depth_ff);
   assign mix_eff   = (mix_ff > SMP_W'(ONE_Q15)) ? MUL_A_W'(ONE_Q15) : MUL_A_W'(mix_ff);
   assign dry_eff   = MUL_A_W'(ONE_Q15) - mix_eff;

   // entries never written read as zero
   assign rd_in  = rd_vld_ff ? signed'(mem_rd_ff[2*SIG_W-1 -: SIG_W]) : '0;
   assign rd_out = rd_vld_ff ? signed'(mem_rd_ff[SIG_W-1:0]) : '0;

   assign y_new   = SIG_W'(clip(SAT_W'(rnd_q15(prod_ff)) + SAT_W'(prev_in_ff), SIG_HI, SIG_LO));
   assign mix_sum = acc_ff + prod_ff;
   assign rd_addr = (state_ff == ST_COEF) ? '0 : stage_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN:     state_in = ST_GAIN_RND;
         ST_GAIN_RND: state_in = ST_COEF;
         ST_COEF:     state_in = ST_COEF_RND;
         ST_COEF_RND: state_in = ST_STG_MUL;
         ST_STG_DIF:  state_in = ST_STG_MUL;
         ST_STG_MUL:  state_in = ST_STG_RND;
         ST_STG_RND:  state_in = last_stage ? ST_WET : ST_STG_DIF;
         ST_WET:      state_in = ST_MIX;
         ST_MIX:      state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl          = '0;
      ctrl.mul_sel  = MUL_GAIN;
      unique case (state_ff)
         ST_IDLE:     ctrl.req_ready = 1'b1;
         ST_GAIN: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_GAIN;
         end
         ST_GAIN_RND: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_FB;
         end
         ST_COEF: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_COEF;
            ctrl.mem_re  = 1'b1;
         end
         ST_STG_MUL: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_STAGE;
         end
         ST_STG_RND: begin
            ctrl.mem_we  = 1'b1;
            ctrl.mem_re  = !last_stage;
         end
         ST_WET: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_DRY;
         end
         ST_MIX: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_WET;
         end
         ST_OUT:      ctrl.out_load = !rsp_valid_ff || rsp_ready;
         default:     ctrl.req_ready = 1'b0;
      endcase
   end

   // shared multiplier operands
   always_comb begin
      case (ctrl.mul_sel)
         MUL_GAIN: begin
            mul_a = signed'(depth_eff);
            mul_b = MUL_B_W'(GAIN_09);
         end
         MUL_FB: begin
            mul_a = MUL_A_W'(fbg_ff);
            mul_b = MUL_B_W'(wet_fb_ff);
         end
         MUL_COEF: begin
            mul_a = MUL_A_W'(g_ff);
            mul_b = MUL_B_W'(sine_ff);
         end
         MUL_STAGE: begin
            mul_a = MUL_A_W'(a_ff);
            mul_b = d_ff;
         end
         MUL_DRY: begin
            mul_a = signed'(dry_eff);
            mul_b = MUL_B_W'(x_in_ff);
         end
         MUL_WET: begin
            mul_a = signed'(mix_eff);
            mul_b = MUL_B_W'(wet_fb_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         step_ff      <= '0;
         depth_ff     <= '0;
         fbg_ff       <= '0;
         mix_ff       <= '0;
         wet_fb_ff    <= '0;
         vld_ff       <= '0;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_idx_type'(csr_index))
               CSR_PHASE_STEP:    step_ff  <= csr_wdata;
               CSR_SWEEP_DEPTH:   depth_ff <= csr_wdata[SMP_W-1:0];
               CSR_FEEDBACK_GAIN: fbg_ff   <= signed'(csr_wdata[SMP_W-1:0]);
               CSR_WET_MIX:       mix_ff   <= csr_wdata[SMP_W-1:0];
            endcase
         end
         // advance the LFO after the sine is sampled
         if (req_acc) begin
            phase_ff <= phase_ff + PHASE_W'(step_ff);
         end
         if (state_ff == ST_COEF) begin
            stage_ff <= '0;
         end else if (state_ff == ST_STG_RND && !last_stage) begin
            stage_ff <= stage_ff + 1'b1;
         end
         if (ctrl.mem_we) begin
            vld_ff[stage_ff] <= 1'b1;
         end
         if (state_ff == ST_WET) begin
            wet_fb_ff <= SIG_W'(clip(SAT_W'(sig_ff), WET_HI, WET_LO));
         end
         if (ctrl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_in_ff <= req_sample_in;
         sine_ff <= sine_tab[phase_ff[PHASE_W-1 -: SINE_TABLE_BITS]];
      end
      if (ctrl.mul_en) begin
         prod_ff <= mul_p;
      end
      case (state_ff)
         ST_GAIN_RND: g_ff <= COEF_W'(rnd_q15(prod_ff));
         ST_COEF: begin
            sig_ff <= SIG_W'(clip(SAT_W'(x_in_ff) + SAT_W'(rnd_q15(prod_ff)), SIG_HI, SIG_LO));
         end
         ST_COEF_RND: begin
            a_ff       <= COEF_W'(rnd_q15(prod_ff));
            d_ff       <= DIF_W'(sig_ff) - DIF_W'(rd_out);
            prev_in_ff <= rd_in;
         end
         ST_STG_DIF: begin
            d_ff       <= DIF_W'(sig_ff) - DIF_W'(rd_out);
            prev_in_ff <= rd_in;
         end
         ST_STG_RND:  sig_ff <= y_new;
         ST_MIX:      acc_ff <= prod_ff;
         ST_OUT: begin
            if (ctrl.out_load) begin
               rsp_data_ff <= SMP_W'(clip(SAT_W'(rnd_q15(mix_sum)), OUT_HI, OUT_LO));
            end
         end
         default: ;
      endcase
   end

   // stage history: {prev_in, prev_out}; a stage's entry is read and written
   // back before the next stage, so accesses to one entry never overlap
   always_ff @(posedge clock) begin
      if (ctrl.mem_we) begin
         stage_mem[stage_ff] <= {sig_ff, y_new};
      end
      if (ctrl.mem_re) begin
         mem_rd_ff <= stage_mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_GAIN)
      else $error("accepted item did not start the sequence");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> $stable(phase_ff))
      else $error("LFO phase moved without an item");

   a_all_stages_written: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> &vld_ff)
      else $error("result reached output with a stage entry never written");

   a_out_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_valid_ff && !rsp_ready
      |=> state_ff == ST_OUT && $stable(rsp_sample_out))
      else $error("pending result overwritten");

endmodule
